>>> rtl/cwma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Centered weighted moving average: shared package
// Field widths, queue size and the state types of the front and back parts.
// ----------------------------------------------------------------------------
package cwma_pkg;

  localparam int COUNT_W     = 20;
  localparam int MEAN_W      = 16;
  localparam int PROD_W      = COUNT_W + MEAN_W;
  localparam int QUOT_W      = 16;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SHIFT,
    F_WALK
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

>>> rtl/cwma_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Centered weighted moving average: job queue
// Small first-in first-out buffer between the window front and the divider.
// ----------------------------------------------------------------------------
module cwma_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic [W-1:0]      pop_data
);
  import cwma_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != CW'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/cwma_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Centered weighted moving average: window front
// Holds the recent days, keeps running window totals and issues one
// division job per result, walking the partial sums for the flush results.
// ----------------------------------------------------------------------------
module cwma_front #(
  parameter int WINDOW = 7
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [cwma_pkg::COUNT_W-1:0] in_count,
  input  wire logic [cwma_pkg::MEAN_W-1:0]  in_mean,
  input  wire logic                         in_last,
  output logic                              job_valid,
  input  wire logic                         job_ready,
  output logic [cwma_pkg::COUNT_W+$clog2(2*((WINDOW-1)/2)+1)-1:0] job_csum,
  output logic [cwma_pkg::PROD_W+$clog2(2*((WINDOW-1)/2)+1)-1:0]  job_psum,
  output logic                              job_last
);
  import cwma_pkg::*;

  localparam int HALF   = (WINDOW - 1) / 2;
  localparam int SPAN   = 2 * HALF + 1;
  localparam int CSUM_W = COUNT_W + $clog2(SPAN);
  localparam int PSUM_W = PROD_W + $clog2(SPAN);
  localparam int IW     = (SPAN > 1) ? $clog2(SPAN) : 1;
  localparam int DS_W   = $clog2(SPAN + 1);

  front_state_t state;
  front_state_t state_next;

  logic [COUNT_W-1:0] counts [SPAN];
  logic [PROD_W-1:0]  prods  [SPAN];
  logic [CSUM_W-1:0]  tot_c;
  logic [PSUM_W-1:0]  tot_p;
  logic [CSUM_W-1:0]  run_c;
  logic [PSUM_W-1:0]  run_p;
  logic [DS_W-1:0]    days_seen;
  logic [IW-1:0]      hi;
  logic [IW-1:0]      k_cur;
  logic               reg_pend;
  logic               flush_pend;
  logic [COUNT_W-1:0] cnt_in;
  logic [MEAN_W-1:0]  mean_in;
  logic               last_in;

  logic [PROD_W-1:0]  prod_new;
  logic [CSUM_W-1:0]  tot_c_next;
  logic [PSUM_W-1:0]  tot_p_next;
  logic [DS_W-1:0]    days_seen_next;
  logic [IW-1:0]      k_init;
  logic [IW:0]        target;
  logic               sub_step;
  logic               done;

  always_comb begin
    prod_new   = PROD_W'(cnt_in) * PROD_W'(mean_in);
    tot_c_next = tot_c + CSUM_W'(cnt_in) - CSUM_W'(counts[SPAN-1]);
    tot_p_next = tot_p + PSUM_W'(prod_new) - PSUM_W'(prods[SPAN-1]);
    if (days_seen == DS_W'(SPAN)) begin
      days_seen_next = days_seen;
    end else begin
      days_seen_next = days_seen + 1'b1;
    end
    if (HALF == 0) begin
      k_init = '0;
    end else if (days_seen_next > DS_W'(HALF)) begin
      k_init = IW'(HALF - 1);
    end else begin
      k_init = IW'(days_seen_next - 1'b1);
    end
    target = {1'b0, k_cur} + (IW + 1)'(HALF);
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    job_valid  = 1'b0;
    job_last   = 1'b0;
    sub_step   = 1'b0;
    done       = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = F_SHIFT;
        end
      end
      F_SHIFT: begin
        state_next = F_WALK;
      end
      F_WALK: begin
        if (reg_pend) begin
          job_valid = 1'b1;
          job_last  = last_in && (HALF == 0);
        end else if (flush_pend) begin
          if ({1'b0, hi} > target) begin
            sub_step = 1'b1;
          end else begin
            job_valid = 1'b1;
            job_last  = (k_cur == '0);
          end
        end else begin
          done       = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  assign job_csum = run_c;
  assign job_psum = run_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cnt_in  <= in_count;
      mean_in <= in_mean;
      last_in <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (done && last_in)) begin
      for (int j = 0; j < SPAN; j++) begin
        counts[j] <= '0;
        prods[j]  <= '0;
      end
      tot_c     <= '0;
      tot_p     <= '0;
      days_seen <= '0;
    end else if (state == F_SHIFT) begin
      counts[0] <= cnt_in;
      prods[0]  <= prod_new;
      for (int j = 1; j < SPAN; j++) begin
        counts[j] <= counts[j-1];
        prods[j]  <= prods[j-1];
      end
      tot_c     <= tot_c_next;
      tot_p     <= tot_p_next;
      days_seen <= days_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_pend   <= 1'b0;
      flush_pend <= 1'b0;
      hi         <= '0;
      k_cur      <= '0;
      run_c      <= '0;
      run_p      <= '0;
    end else if (state == F_SHIFT) begin
      reg_pend   <= (days_seen_next > DS_W'(HALF));
      flush_pend <= last_in && (HALF > 0);
      hi         <= IW'(SPAN - 1);
      k_cur      <= k_init;
      run_c      <= tot_c_next;
      run_p      <= tot_p_next;
    end else begin
      if (sub_step) begin
        run_c <= run_c - CSUM_W'(counts[hi]);
        run_p <= run_p - PSUM_W'(prods[hi]);
        hi    <= hi - 1'b1;
      end
      if (job_valid && job_ready) begin
        if (reg_pend) begin
          reg_pend <= 1'b0;
        end else if (k_cur == '0) begin
          flush_pend <= 1'b0;
        end else begin
          k_cur <= k_cur - 1'b1;
        end
      end
    end
  end

  a_days_bound: assert property (@(posedge clk) disable iff (rst)
    days_seen <= DS_W'(SPAN))
    else $error("day count above window span");

  a_walk_order: assert property (@(posedge clk) disable iff (rst)
    (state == F_WALK && !reg_pend && flush_pend) |-> ({1'b0, hi} >= target))
    else $error("partial sum walked below its target");

  a_accept_shift: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == F_SHIFT))
    else $error("accepted word not shifted in");

endmodule

`default_nettype wire

>>> rtl/cwma_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Centered weighted moving average: divider back end
// Restoring division of the product sum by the count sum, one quotient bit
// per cycle, into a registered output word.
// ----------------------------------------------------------------------------
module cwma_back #(
  parameter int WINDOW = 7
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         job_valid,
  output logic                              job_ready,
  input  wire logic [cwma_pkg::COUNT_W+$clog2(2*((WINDOW-1)/2)+1)-1:0] job_csum,
  input  wire logic [cwma_pkg::PROD_W+$clog2(2*((WINDOW-1)/2)+1)-1:0]  job_psum,
  input  wire logic                         job_last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [cwma_pkg::QUOT_W-1:0]       out_value,
  output logic                              out_no_data,
  output logic                              out_last
);
  import cwma_pkg::*;

  localparam int HALF   = (WINDOW - 1) / 2;
  localparam int SPAN   = 2 * HALF + 1;
  localparam int CSUM_W = COUNT_W + $clog2(SPAN);
  localparam int PSUM_W = PROD_W + $clog2(SPAN);
  localparam int SW     = $clog2(QUOT_W);

  back_state_t state;
  back_state_t state_next;

  logic [CSUM_W-1:0] divisor;
  logic [CSUM_W-1:0] rem;
  logic [QUOT_W-1:0] quot;
  logic [SW-1:0]     step;
  logic              zero;
  logic              last_q;

  logic [CSUM_W:0]   trial;
  logic              fits;
  logic              take;
  logic              load_out;

  always_comb begin
    trial = {rem, quot[QUOT_W-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = (job_csum == '0) ? B_DONE : B_DIV;
        end
      end
      B_DIV: begin
        if (step == SW'(QUOT_W - 1)) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  assign take = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      divisor <= job_csum;
      rem     <= job_psum[PSUM_W-1:QUOT_W];
      quot    <= job_psum[QUOT_W-1:0];
      zero    <= (job_csum == '0);
      last_q  <= job_last;
      step    <= '0;
    end else if (state == B_DIV) begin
      rem  <= fits ? CSUM_W'(trial - {1'b0, divisor}) : CSUM_W'(trial);
      quot <= {quot[QUOT_W-2:0], fits};
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value   <= zero ? '0 : quot;
      out_no_data <= zero;
      out_last    <= last_q;
    end
  end

  a_nodata_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_no_data) |-> (out_value == '0))
    else $error("empty window gave a nonzero value");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (divisor != '0))
    else $error("division started with a zero count sum");

endmodule

`default_nettype wire

>>> rtl/centered_weighted_moving_average.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Centered weighted moving average
// Count-weighted mean of daily Q8.8 values over a centered odd window.
// ----------------------------------------------------------------------------
// Input channel s_axis: one word per day, tlast on the final day of a series.
// Output channel m_axis: one word per day, a Q8.8 mean rounded down, tuser set
// when the window holds no count, tlast on the result of the final day.
// The result for a day leaves once the day half a window later is in; the
// final day also flushes the remaining results, up to (WINDOW-1)/2 words.
// An input word is accepted, shifted into the window and then walked: one
// division job for each result it causes, one step per older day dropped
// from the partial sum on the final day, and a closing step. Each result
// then passes through the bit-serial divider (16 quotient bits), which an
// empty window skips; the divider takes no new job until its result is
// loaded into the output word, so it sets the sustained throughput.
// A four-entry job queue separates window and divider, and a registered
// output word lets the divider start the next job while the receiver stalls;
// a stall longer than the queue holds back the input side.
// Reset empties the window and the queue; after the final day the window
// returns to its reset contents and the next word starts a new series.
// ----------------------------------------------------------------------------
module centered_weighted_moving_average #(
  parameter int WINDOW = 7
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // daily_count[19:0], mean_secondary[35:20]
  input  wire logic        s_axis_tlast,  // last_day
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // smoothed_value[15:0]
  output logic [0:0]       m_axis_tuser,  // no_data[0]
  output logic             m_axis_tlast   // last_out
);
  import cwma_pkg::*;

  localparam int HALF   = (WINDOW - 1) / 2;
  localparam int SPAN   = 2 * HALF + 1;
  localparam int CSUM_W = COUNT_W + $clog2(SPAN);
  localparam int PSUM_W = PROD_W + $clog2(SPAN);
  localparam int JOB_W  = CSUM_W + PSUM_W + 1;

  logic              fj_valid;
  logic              fj_ready;
  logic [CSUM_W-1:0] fj_csum;
  logic [PSUM_W-1:0] fj_psum;
  logic              fj_last;
  logic              bj_valid;
  logic              bj_ready;
  logic [JOB_W-1:0]  bj_data;
  logic              nd;

  cwma_front #(
    .WINDOW(WINDOW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_count  (s_axis_tdata[COUNT_W-1:0]),
    .in_mean   (s_axis_tdata[COUNT_W+MEAN_W-1:COUNT_W]),
    .in_last   (s_axis_tlast),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job_csum  (fj_csum),
    .job_psum  (fj_psum),
    .job_last  (fj_last)
  );

  cwma_queue #(
    .W(JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_data  ({fj_last, fj_psum, fj_csum}),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_data   (bj_data)
  );

  cwma_back #(
    .WINDOW(WINDOW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (bj_valid),
    .job_ready   (bj_ready),
    .job_csum    (bj_data[CSUM_W-1:0]),
    .job_psum    (bj_data[CSUM_W+PSUM_W-1:CSUM_W]),
    .job_last    (bj_data[JOB_W-1]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_value   (m_axis_tdata),
    .out_no_data (nd),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tuser = nd;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Centered weighted moving average: testbench
// Sends daily series, from single days to long runs, through the input
// stream and predicts every windowed mean from its own copy of the window.
// Each result word is checked against the oldest prediction. Both sides idle
// at random, and the receiver also stalls long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  import cwma_pkg::*;

  localparam int WIN  = 7;
  localparam int HALF = (WIN - 1) / 2;
  localparam int SPAN = 2 * HALF + 1;

  typedef struct packed {
    logic [QUOT_W-1:0] value;
    logic              empty;
    logic              last;
  } day_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic [COUNT_W-1:0] day_counts [SPAN];
  logic [PROD_W-1:0]  day_products [SPAN];
  int                 held_days;
  day_result_t        pending_days [$];

  bit source_idles = 1'b0;
  bit sink_idles = 1'b0;
  bit slow_sink = 1'b0;
  int stall_left = 0;

  int errors = 0;
  int reported = 0;
  int days_sent = 0;
  int series_sent = 0;
  int means_checked = 0;
  int empty_windows = 0;

  always #6 clk = ~clk;

  centered_weighted_moving_average #(.WINDOW(WIN)) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void clear_window();
    for (int j = 0; j < SPAN; j++) begin
      day_counts[j] = '0;
      day_products[j] = '0;
    end
    held_days = 0;
  endfunction

  // Window for the day k places back from the newest one, cut off at the
  // start of the series and at the newest day held.
  function automatic day_result_t window_result(int k, bit is_last);
    logic [63:0] count_sum;
    logic [63:0] product_sum;
    int          hi;
    day_result_t r;
    count_sum = '0;
    product_sum = '0;
    hi = k + HALF;
    if (hi > held_days - 1) hi = held_days - 1;
    if (hi > SPAN - 1) hi = SPAN - 1;
    for (int j = 0; j <= hi; j++) begin
      count_sum += day_counts[j];
      product_sum += day_products[j];
    end
    if (count_sum == 0) begin
      r.value = '0;
      r.empty = 1'b1;
    end else begin
      r.value = QUOT_W'(product_sum / count_sum);
      r.empty = 1'b0;
    end
    r.last = is_last;
    return r;
  endfunction

  function automatic void queue_result(day_result_t r);
    pending_days.insert(pending_days.size(), r);
  endfunction

  task automatic predict_day(input logic [COUNT_W-1:0] count, input logic [MEAN_W-1:0] mean,
                             input bit last);
    int top;
    for (int j = SPAN - 1; j > 0; j--) begin
      day_counts[j] = day_counts[j-1];
      day_products[j] = day_products[j-1];
    end
    day_counts[0] = count;
    day_products[0] = PROD_W'(count) * PROD_W'(mean);
    if (held_days < SPAN) held_days++;
    if (held_days > HALF) queue_result(window_result(HALF, last && HALF == 0));
    if (last) begin
      top = held_days - 1;
      if (top > HALF - 1) top = HALF - 1;
      for (int k = top; k >= 0; k--) queue_result(window_result(k, k == 0));
      clear_window();
      series_sent++;
    end
  endtask

  task automatic send_day(input logic [COUNT_W-1:0] count, input logic [MEAN_W-1:0] mean,
                          input bit last);
    int gap;
    gap = source_idles ? idle_length() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, mean, count};
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_day(count, mean, last);
    days_sent++;
  endtask

  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return {COUNT_W{1'b1}} - COUNT_W'($urandom_range(0, 15));
    if (r < 55) return COUNT_W'($urandom_range(1, 255));
    return COUNT_W'($urandom());
  endfunction

  function automatic logic [MEAN_W-1:0] pick_mean();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return {MEAN_W{1'b1}};
    return MEAN_W'($urandom());
  endfunction

  task automatic send_series(input int length, input bit all_zero);
    for (int d = 0; d < length; d++) begin
      send_day(all_zero ? '0 : pick_count(), pick_mean(), d == length - 1);
    end
  endtask

  task automatic test_edges();
    logic [COUNT_W-1:0] cmax;
    logic [MEAN_W-1:0]  mmax;
    cmax = {COUNT_W{1'b1}};
    mmax = {MEAN_W{1'b1}};
    source_idles = 1'b0;
    sink_idles = 1'b0;
    send_day(cmax, mmax, 1'b1);
    send_day('0, mmax, 1'b1);
    send_day('0, 16'h0100, 1'b0);
    send_day('0, 16'h0200, 1'b1);
    send_day(20'd3, 16'h0180, 1'b0);
    send_day('0, mmax, 1'b0);
    send_day(20'd1, '0, 1'b1);
    for (int d = 0; d < 5; d++) send_day(d[0] ? cmax : 20'd1, d[0] ? '0 : mmax, d == 4);
    for (int d = 0; d < 8; d++) send_day(d[1] ? '0 : cmax, d[0] ? mmax : 16'h0001, d == 7);
  endtask

  task automatic test_random_series(input int budget);
    int sent;
    int length;
    int r;
    sent = 0;
    source_idles = 1'b1;
    sink_idles = 1'b1;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 10) length = $urandom_range(1, 3);
      else if (r < 80) length = $urandom_range(4, 12);
      else length = $urandom_range(13, 30);
      send_series(length, $urandom_range(0, 9) == 0);
      sent += length;
    end
  endtask

  task automatic test_full_rate();
    source_idles = 1'b0;
    sink_idles = 1'b0;
    send_series(12, 1'b0);
    send_series(2, 1'b0);
  endtask

  task automatic test_slow_receiver();
    source_idles = 1'b0;
    sink_idles = 1'b1;
    slow_sink = 1'b1;
    send_series(10, 1'b0);
    send_series(3, 1'b0);
    slow_sink = 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left == 0 && sink_idles && $urandom_range(0, 3) == 0) begin
      stall_left = slow_sink ? $urandom_range(20, 60) : idle_length();
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    day_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      means_checked++;
      if (m_axis_tuser[0]) empty_windows++;
      if (pending_days.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected word: value %h no_data %b last %b", m_axis_tdata,
                   m_axis_tuser[0], m_axis_tlast);
        end
      end else begin
        want = pending_days.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tuser[0] !== want.empty ||
            m_axis_tlast !== want.last) begin
          errors++;
          if (reported < 10) begin
            reported++;
            $display("mismatch: expected value %h no_data %b last %b, got %h %b %b",
                     want.value, want.empty, want.last, m_axis_tdata, m_axis_tuser[0],
                     m_axis_tlast);
          end
        end
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int guard;
    clear_window();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_edges();
    test_random_series(120);
    test_full_rate();
    test_slow_receiver();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
    sink_idles = 1'b0;
    while (pending_days.size() != 0) @(posedge clk);
    guard = 0;
    while (guard < 100) begin
      @(posedge clk);
      guard++;
    end
    $display("%0d days in %0d series sent, %0d smoothed words checked,", days_sent,
             series_sent, means_checked);
    $display("%0d of them empty windows, %0d failures", empty_windows, errors);
    if (errors == 0 && pending_days.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cwma_pkg.sv
rtl/cwma_queue.sv
rtl/cwma_front.sv
rtl/cwma_back.sv
rtl/centered_weighted_moving_average.sv
tb/testbench.sv
